[src/lon_pkg.sv]
// Shared types and constants for the literal occurrence normalizer.
`default_nettype none
package lon_pkg;

	localparam int unsigned ENTRY_W  = 32;
	localparam int unsigned IDX_W    = 11;
	localparam int unsigned SIZE_W   = 16;
	localparam int unsigned REL_W    = 17;
	localparam int unsigned VCNT_W   = 11;
	localparam int unsigned DVD_W    = 48;
	localparam int unsigned QUO_W    = 17;

	localparam logic [1:0] CMD_ACCUM = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_MAX_ZERO = 2'd1;
	localparam logic [1:0] STAT_RANGE    = 2'd2;

	localparam logic [REL_W-1:0]  ONE_Q16         = 17'd65536;
	localparam logic [VCNT_W-1:0] VAR_COUNT_RESET = 11'd1024;

	typedef struct packed {
		logic [1:0]        command;
		logic [IDX_W-1:0]  literal_index;
		logic [SIZE_W-1:0] clause_size;
	} lon_req_t;

	typedef struct packed {
		logic [REL_W-1:0] relative_occurrence;
		logic [1:0]       status;
	} lon_rsp_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} lon_div_stat_t;

endpackage
`default_nettype wire

[src/lon_store.sv]
// Single-port occurrence memory with registered read.
`default_nettype none
module lon_store #(
	parameter int unsigned DEPTH = 2048,
	parameter int unsigned AW    = 11
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic                       re,
	input  wire logic [AW-1:0]              addr,
	input  wire logic [lon_pkg::ENTRY_W-1:0] wdata,
	output logic      [lon_pkg::ENTRY_W-1:0] rdata
);
	import lon_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[src/lon_div.sv]
// Restoring divider, one quotient bit per cycle, 17 quotient bits.
`default_nettype none
module lon_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [lon_pkg::DVD_W-1:0]   dividend,
	input  wire logic [lon_pkg::ENTRY_W-1:0] divisor,
	output lon_pkg::lon_div_stat_t           stat
);
	import lon_pkg::*;

	// quotient is known to stay below 2^QUO_W, so the upper dividend bits
	// start out as a remainder smaller than the divisor
	logic                busy_q;
	logic                done_q;
	logic [4:0]          cnt_q;
	logic [ENTRY_W-1:0]  rem_q;
	logic [ENTRY_W-1:0]  dvs_q;
	logic [QUO_W-1:0]    dvd_q;
	logic [QUO_W-1:0]    quo_q;
	logic [ENTRY_W:0]    trial;
	logic                fits;

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ENTRY_W'(dividend[DVD_W-1:QUO_W]);
			dvd_q <= dividend[QUO_W-1:0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? ENTRY_W'(trial - {1'b0, dvs_q}) : trial[ENTRY_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign stat.done     = done_q;
	assign stat.quotient = quo_q;

endmodule
`default_nettype wire

[src/literal_occurrence_normalizer_unit.sv]
// Top level of the literal occurrence normalizer: sequencer, max register, config.
`default_nettype none
// Weighted literal histogram with Q1.16 normalized readout. One request is
// worked at a time. An accumulate reads its entry and starts the shared
// 17-step restoring divider on its accept, then writes the entry back when the
// divider is done; a query reads its entry, then runs the divider and goes to
// its response step (a query that fails its range or zero-maximum check goes
// straight to the response step, an ignored request leaves the unit idle). A
// query also waits in its last step while an earlier response is still held.
// A clear request, and reset, run a clearing pass through all 2*MAX_VARS
// entries (2048 at the default) of the entry memory, one entry per cycle,
// during which req_stall stays high; configuration writes are taken at any
// time. The result register frees the response side from the request side:
// a new request is taken while a response waits.
module literal_occurrence_normalizer_unit #(
	parameter int unsigned MAX_VARS = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire lon_pkg::lon_req_t           req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output lon_pkg::lon_rsp_t                rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [lon_pkg::VCNT_W-1:0]  cfg_data
);
	import lon_pkg::*;

	localparam int unsigned DEPTH = 2 * MAX_VARS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_DIV,
		S_RESP
	} state_t;

	state_t              state_q;
	logic [VCNT_W-1:0]   var_count_q;
	logic [ENTRY_W-1:0]  max_q;
	logic [AW-1:0]       clr_addr_q;
	logic [AW-1:0]       addr_q;
	logic [1:0]          cmd_q;
	lon_rsp_t            res_q;
	lon_rsp_t            rsp_q;
	logic                rsp_valid_q;

	logic                accept;
	logic                idx_valid;
	logic                mem_we;
	logic                mem_re;
	logic [AW-1:0]       mem_addr;
	logic [ENTRY_W-1:0]  mem_wdata;
	logic [ENTRY_W-1:0]  mem_rdata;
	logic                div_start;
	logic [DVD_W-1:0]    div_dividend;
	logic [ENTRY_W-1:0]  div_divisor;
	lon_div_stat_t       div_stat;
	logic [ENTRY_W:0]    sum_wide;
	logic [ENTRY_W-1:0]  sum_sat;
	logic [REL_W-1:0]    rel_clamped;
	logic                slot_free;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign idx_valid = ({1'b0, req.literal_index} < {var_count_q, 1'b0})
	                && (18'(req.literal_index) < 18'(DEPTH));

	assign sum_wide = {1'b0, mem_rdata} + (ENTRY_W + 1)'(div_stat.quotient);
	assign sum_sat  = sum_wide[ENTRY_W] ? '1 : sum_wide[ENTRY_W-1:0];

	assign rel_clamped = (div_stat.quotient > ONE_Q16) ? ONE_Q16 : div_stat.quotient;

	// memory port and divider steering
	always_comb begin
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_addr     = addr_q;
		mem_wdata    = sum_sat;
		div_start    = 1'b0;
		div_dividend = DVD_W'(ONE_Q16);
		div_divisor  = ENTRY_W'(req.clause_size);
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_addr = AW'(req.literal_index);
				if (accept && req.command == CMD_ACCUM && idx_valid
				    && req.clause_size != '0) begin
					mem_re    = 1'b1;
					div_start = 1'b1;
				end
				if (accept && req.command == CMD_QUERY && idx_valid
				    && max_q != '0) begin
					mem_re = 1'b1;
				end
			end
			S_READ: begin
				div_start    = 1'b1;
				div_dividend = {mem_rdata, 16'd0};
				div_divisor  = max_q;
			end
			S_DIV: begin
				mem_we = div_stat.done && (cmd_q == CMD_ACCUM);
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			var_count_q <= VAR_COUNT_RESET;
			max_q       <= '0;
			clr_addr_q  <= '0;
			addr_q      <= '0;
			cmd_q       <= CMD_ACCUM;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				var_count_q <= cfg_data;
			end
			// drop the taken response; S_RESP reloads the register itself
			if (rsp_valid_q && !rsp_stall && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q  <= req.command;
						addr_q <= AW'(req.literal_index);
						case (req.command)
							CMD_ACCUM: begin
								if (idx_valid && req.clause_size != '0) begin
									state_q <= S_DIV;
								end
							end
							CMD_QUERY: begin
								res_q.relative_occurrence <= '0;
								if (!idx_valid) begin
									res_q.status <= STAT_RANGE;
									state_q      <= S_RESP;
								end else if (max_q == '0) begin
									res_q.status <= STAT_MAX_ZERO;
									state_q      <= S_RESP;
								end else begin
									state_q <= S_READ;
								end
							end
							CMD_CLEAR: begin
								max_q      <= '0;
								clr_addr_q <= '0;
								state_q    <= S_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (cmd_q == CMD_ACCUM) begin
							if (sum_sat > max_q) begin
								max_q <= sum_sat;
							end
							state_q <= S_IDLE;
						end else begin
							res_q.relative_occurrence <= rel_clamped;
							res_q.status              <= STAT_OK;
							state_q                   <= S_RESP;
						end
					end
				end
				S_RESP: begin
					// hold until the response register is free
					if (slot_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	lon_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	lon_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat)
	);

endmodule
`default_nettype wire
